>>> design/aabbs_pkg.sv
`default_nettype none

package aabbs_pkg;

	// coordinate and tolerance widths
	localparam int COORD_W = 32;
	localparam int EPS_W   = 16;

	// job queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [EPS_W-1:0]   eps_t;

	// one input item: box and cutter corners
	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t cut_min_x;
		coord_t cut_min_y;
		coord_t cut_min_z;
		coord_t cut_max_x;
		coord_t cut_max_y;
		coord_t cut_max_z;
	} box_item_t;

	// one result item: a remainder piece
	typedef struct packed {
		coord_t piece_min_x;
		coord_t piece_min_y;
		coord_t piece_min_z;
		coord_t piece_max_x;
		coord_t piece_max_y;
		coord_t piece_max_z;
		logic   last_piece;
	} piece_item_t;

	// slab selection codes, in emission order
	typedef logic [5:0] slab_mask_t;
	localparam slab_mask_t SLAB_NONE = 6'b000000;
	localparam slab_mask_t SLAB_X_LO = 6'b000001;
	localparam slab_mask_t SLAB_X_HI = 6'b000010;
	localparam slab_mask_t SLAB_Y_LO = 6'b000100;
	localparam slab_mask_t SLAB_Y_HI = 6'b001000;
	localparam slab_mask_t SLAB_Z_LO = 6'b010000;
	localparam slab_mask_t SLAB_Z_HI = 6'b100000;

	// classified job: box corners, intersection corners, slabs to emit
	typedef struct packed {
		coord_t [2:0] bn;
		coord_t [2:0] bx;
		coord_t [2:0] on;
		coord_t [2:0] ox;
		slab_mask_t   mask;
		logic         pass;
	} slab_job_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// hi exceeds lo by strictly more than eps, exact over the full range
	function automatic logic exceeds(coord_t hi, coord_t lo, eps_t eps);
		logic [COORD_W:0] diff;
		diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
		return !diff[COORD_W] && (diff[COORD_W-1:0] > COORD_W'(eps));
	endfunction

	function automatic coord_t smax(coord_t a, coord_t b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

	function automatic coord_t smin(coord_t a, coord_t b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

endpackage

`default_nettype wire

>>> design/aabbs_front.sv
`default_nettype none

module aabbs_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  aabbs_pkg::box_item_t     box,
	input  aabbs_pkg::eps_t          epsilon,
	input  aabbs_pkg::q_stat_t       q_stat,
	output logic                     q_push,
	output aabbs_pkg::slab_job_t     q_job
);

	aabbs_pkg::coord_t [2:0] bn_c, bx_c, cn_c, cx_c, on_c, ox_c;
	logic [2:0]              axis_ovl_c;

	logic                    valid_s1;
	logic                    pass_s1;
	aabbs_pkg::coord_t [2:0] bn_s1, bx_s1, on_s1, ox_s1;

	// unpack corners per axis
	assign bn_c = {box.box_min_z, box.box_min_y, box.box_min_x};
	assign bx_c = {box.box_max_z, box.box_max_y, box.box_max_x};
	assign cn_c = {box.cut_min_z, box.cut_min_y, box.cut_min_x};
	assign cx_c = {box.cut_max_z, box.cut_max_y, box.cut_max_x};

	// overlap test and intersection corners
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			axis_ovl_c[i] = aabbs_pkg::exceeds(cx_c[i], bn_c[i], epsilon) &&
				aabbs_pkg::exceeds(bx_c[i], cn_c[i], epsilon);
			on_c[i] = aabbs_pkg::smax(bn_c[i], cn_c[i]);
			ox_c[i] = aabbs_pkg::smin(bx_c[i], cx_c[i]);
		end
	end

	// stage stalls only while its job cannot enter the queue
	assign full   = valid_s1 && q_stat.full;
	assign q_push = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			bn_s1   <= bn_c;
			bx_s1   <= bx_c;
			on_s1   <= on_c;
			ox_s1   <= ox_c;
			pass_s1 <= !(&axis_ovl_c);
		end
	end

	// slab thickness checks build the job
	always_comb begin
		q_job.bn   = bn_s1;
		q_job.bx   = bx_s1;
		q_job.on   = on_s1;
		q_job.ox   = ox_s1;
		q_job.pass = pass_s1;
		q_job.mask = aabbs_pkg::SLAB_NONE;
		if (!pass_s1) begin
			for (int i = 0; i < 3; i++) begin
				q_job.mask[2*i]   = aabbs_pkg::exceeds(on_s1[i], bn_s1[i], epsilon);
				q_job.mask[2*i+1] = aabbs_pkg::exceeds(bx_s1[i], ox_s1[i], epsilon);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/aabbs_queue.sv
`default_nettype none

module aabbs_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wr_en,
	input  aabbs_pkg::slab_job_t     wr_data,
	input  wire                      rd_en,
	output aabbs_pkg::slab_job_t     rd_data,
	output aabbs_pkg::q_stat_t       stat
);

	aabbs_pkg::slab_job_t               entry_q [aabbs_pkg::Q_DEPTH];
	logic [aabbs_pkg::Q_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [aabbs_pkg::Q_CNT_W-1:0]      cnt_q;
	logic                               do_wr, do_rd;

	assign stat.full  = (cnt_q == aabbs_pkg::Q_CNT_W'(aabbs_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/aabbs_back.sv
`default_nettype none

module aabbs_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  aabbs_pkg::slab_job_t     job,
	input  aabbs_pkg::q_stat_t       q_stat,
	output logic                     q_pop,
	output logic                     empty,
	input  wire                      pop,
	output aabbs_pkg::piece_item_t   piece
);

	aabbs_pkg::slab_mask_t  done_q;
	aabbs_pkg::slab_mask_t  rem, sel;
	logic                   last, slot_free, emit;
	logic                   out_valid_q;
	aabbs_pkg::piece_item_t piece_q;
	aabbs_pkg::piece_item_t piece_c;

	// remaining slabs of the head job, lowest first
	assign rem       = job.mask & ~done_q;
	assign sel       = rem & (~rem + 1'b1);
	assign last      = job.pass || ((rem & ~sel) == aabbs_pkg::SLAB_NONE);
	assign slot_free = !out_valid_q || pop;
	assign emit      = !q_stat.empty && slot_free &&
		(job.pass || (rem != aabbs_pkg::SLAB_NONE));
	assign q_pop     = !q_stat.empty && (job.pass ? slot_free :
		((rem == aabbs_pkg::SLAB_NONE) || (slot_free && last)));

	// piece corners for the selected slab
	always_comb begin
		piece_c.last_piece = last;
		if (job.pass) begin
			piece_c.piece_min_x = job.bn[0];
			piece_c.piece_min_y = job.bn[1];
			piece_c.piece_min_z = job.bn[2];
			piece_c.piece_max_x = job.bx[0];
			piece_c.piece_max_y = job.bx[1];
			piece_c.piece_max_z = job.bx[2];
		end else begin
			case (sel)
				aabbs_pkg::SLAB_X_LO: begin
					piece_c.piece_min_x = job.bn[0];
					piece_c.piece_min_y = job.bn[1];
					piece_c.piece_min_z = job.bn[2];
					piece_c.piece_max_x = job.on[0];
					piece_c.piece_max_y = job.bx[1];
					piece_c.piece_max_z = job.bx[2];
				end
				aabbs_pkg::SLAB_X_HI: begin
					piece_c.piece_min_x = job.ox[0];
					piece_c.piece_min_y = job.bn[1];
					piece_c.piece_min_z = job.bn[2];
					piece_c.piece_max_x = job.bx[0];
					piece_c.piece_max_y = job.bx[1];
					piece_c.piece_max_z = job.bx[2];
				end
				aabbs_pkg::SLAB_Y_LO: begin
					piece_c.piece_min_x = job.on[0];
					piece_c.piece_min_y = job.bn[1];
					piece_c.piece_min_z = job.bn[2];
					piece_c.piece_max_x = job.ox[0];
					piece_c.piece_max_y = job.on[1];
					piece_c.piece_max_z = job.bx[2];
				end
				aabbs_pkg::SLAB_Y_HI: begin
					piece_c.piece_min_x = job.on[0];
					piece_c.piece_min_y = job.ox[1];
					piece_c.piece_min_z = job.bn[2];
					piece_c.piece_max_x = job.ox[0];
					piece_c.piece_max_y = job.bx[1];
					piece_c.piece_max_z = job.bx[2];
				end
				aabbs_pkg::SLAB_Z_LO: begin
					piece_c.piece_min_x = job.on[0];
					piece_c.piece_min_y = job.on[1];
					piece_c.piece_min_z = job.bn[2];
					piece_c.piece_max_x = job.ox[0];
					piece_c.piece_max_y = job.ox[1];
					piece_c.piece_max_z = job.on[2];
				end
				default: begin
					piece_c.piece_min_x = job.on[0];
					piece_c.piece_min_y = job.on[1];
					piece_c.piece_min_z = job.ox[2];
					piece_c.piece_max_x = job.ox[0];
					piece_c.piece_max_y = job.ox[1];
					piece_c.piece_max_z = job.bx[2];
				end
			endcase
		end
	end

	// slabs already sent for the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= aabbs_pkg::SLAB_NONE;
		end else if (q_pop) begin
			done_q <= aabbs_pkg::SLAB_NONE;
		end else if (emit) begin
			done_q <= done_q | sel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			piece_q <= piece_c;
		end
	end

	assign empty = !out_valid_q;
	assign piece = piece_q;

endmodule

`default_nettype wire

>>> design/aabb_subtract_into_slabs.sv
`default_nettype none

// channel   | direction | transfer when           | payload
// ----------+-----------+-------------------------+---------------------
// box       | in        | push && !full           | box (box + cutter)
// piece     | out       | pop && !empty           | piece (+ last_piece)
// cfg       | in        | cfg_valid && cfg_ready  | cfg_data (epsilon)
//
// a box passes the classifier register and the job queue before its first
// piece reaches the result register; the back end then sends one piece per
// cycle while that register is empty or popped. a fully consumed box emits
// no piece. a four-entry job queue between classifier and slab emitter lets
// intake run ahead while pieces wait. reset clears the pipeline and queue,
// epsilon is 1. cfg_ready is always high.

module aabb_subtract_into_slabs (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  aabbs_pkg::box_item_t     box,
	output logic                     empty,
	input  wire                      pop,
	output aabbs_pkg::piece_item_t   piece,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  aabbs_pkg::eps_t          cfg_data
);

	aabbs_pkg::eps_t      epsilon_q;
	aabbs_pkg::slab_job_t wr_job, rd_job;
	aabbs_pkg::q_stat_t   q_stat;
	logic                 q_push, q_pop;

	// tolerance register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= aabbs_pkg::EPS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			epsilon_q <= cfg_data;
		end
	end

	aabbs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.box     (box),
		.epsilon (epsilon_q),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_job   (wr_job)
	);

	aabbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (wr_job),
		.rd_en   (q_pop),
		.rd_data (rd_job),
		.stat    (q_stat)
	);

	aabbs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (rd_job),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.piece   (piece)
	);

endmodule

`default_nettype wire

>>> design/aabbs_checker.sv
`default_nettype none

module aabbs_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      push,
	input wire                      full,
	input wire                      empty,
	input wire                      pop,
	input aabbs_pkg::piece_item_t   piece
);

	// nothing is held or blocked while in reset
	assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("outputs not idle during reset");

	// a waiting piece holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(piece)))
		else $error("piece changed while stalled");

	// the next piece of the same box follows without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !piece.last_piece) |=> !empty)
		else $error("gap inside a box's pieces");

	// the input side cannot block without a transfer behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("input blocked with nothing accepted");

	// a box cannot reach the result side in the cycle after reset release
	assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("piece present right after reset");

endmodule

bind aabb_subtract_into_slabs aabbs_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.piece  (piece)
);

`default_nettype wire
